@@ hdl/assert_macros.svh @@
// Assertion macros shared by the thermostat RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: %m");
// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen: %m");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/stwh_pkg.sv @@
// Types, field widths, codes and the schedule window table of the thermostat.
// No dependencies; used by the interfaces and all RTL modules.
`default_nettype none

package stwh_pkg;

  localparam int unsigned HHMM_W     = 12;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned THR_W      = 7;
  localparam int unsigned HYST_W     = 4;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned ENTRY_W    = 8;
  localparam int unsigned WPOS_W     = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 2'd1;

  localparam logic [THR_W-1:0]  DEFAULT_THR_RST = 7'd40;
  localparam logic [HYST_W-1:0] HYSTERESIS_RST  = 4'd1;

  // schedule windows: a window matches when lo < hhmm < hi
  localparam int unsigned TABLE_SIZE = 9;
  localparam logic [HHMM_W-1:0] WIN_LO [TABLE_SIZE] = '{
    12'd900, 12'd1440, 12'd1500, 12'd1530, 12'd1900,
    12'd2100, 12'd2130, 12'd400, 12'd430};
  localparam logic [HHMM_W-1:0] WIN_HI [TABLE_SIZE] = '{
    12'd1700, 12'd1501, 12'd1531, 12'd1600, 12'd2101,
    12'd2131, 12'd2230, 12'd431, 12'd510};
  localparam logic [THR_W-1:0] WIN_THR [TABLE_SIZE] = '{
    7'd35, 7'd45, 7'd50, 7'd55, 7'd42, 7'd45, 7'd40, 7'd42, 7'd50};

  typedef struct packed {
    logic                     opcode;
    logic                     time_valid;
    logic [HHMM_W-1:0]        time_hhmm;
    logic signed [TEMP_W-1:0] temperature_q4;
    logic [IDX_W-1:0]         read_index;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0]  default_threshold;
    logic [HYST_W-1:0] hysteresis_degrees;
  } cfg_t;

  // control decision for one item
  typedef struct packed {
    logic               heater;
    logic [THR_W-1:0]   thr;
    logic [SLOT_W-1:0]  slot;
    logic               log_en;
    logic [ENTRY_W-1:0] log_byte;
  } ctrl_res_t;

  // request to the history ring
  typedef struct packed {
    logic               wr_en;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
  } hist_req_t;

  // item in flight between accept and output register
  typedef struct packed {
    logic               heater;
    logic [THR_W-1:0]   thr;
    logic [SLOT_W-1:0]  slot;
    logic               is_read;
    logic [ENTRY_W-1:0] entry;
    logic [WPOS_W-1:0]  wpos;
  } stage_t;

  typedef struct packed {
    logic               heater_on;
    logic [THR_W-1:0]   threshold;
    logic [SLOT_W-1:0]  schedule_slot;
    logic [ENTRY_W-1:0] history_entry;
    logic [WPOS_W-1:0]  write_position;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/stwh_if.sv @@
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on stwh_pkg for field widths.
`default_nettype none

interface stwh_in_if import stwh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic                     time_valid;
  logic [HHMM_W-1:0]        time_hhmm;
  logic signed [TEMP_W-1:0] temperature_q4;
  logic [IDX_W-1:0]         read_index;

  modport source (output valid, opcode, time_valid, time_hhmm, temperature_q4, read_index,
                  input ready);
  modport sink (input valid, opcode, time_valid, time_hhmm, temperature_q4, read_index,
                output ready);
endinterface

interface stwh_out_if import stwh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               heater_on;
  logic [THR_W-1:0]   threshold;
  logic [SLOT_W-1:0]  schedule_slot;
  logic [ENTRY_W-1:0] history_entry;
  logic [WPOS_W-1:0]  write_position;

  modport source (output valid, heater_on, threshold, schedule_slot, history_entry,
                  write_position, input ready);
  modport sink (input valid, heater_on, threshold, schedule_slot, history_entry,
                write_position, output ready);
endinterface

interface stwh_cfg_if import stwh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/stwh_ctrl.sv @@
// Schedule lookup and heater hysteresis control; holds the heater level.
// Depends on stwh_pkg.
`default_nettype none

module stwh_ctrl import stwh_pkg::*; #(
  parameter int unsigned NUM_WINDOWS = 9
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      step_i,
  input  item_t     item_i,
  output ctrl_res_t res_o
);

  localparam int unsigned NW_EFF = (NUM_WINDOWS < TABLE_SIZE) ? NUM_WINDOWS : TABLE_SIZE;

  logic                heater_q, heater_d;
  logic [NW_EFF-1:0]   hit;
  logic [THR_W-1:0]    thr;
  logic [SLOT_W-1:0]   slot;
  logic signed [13:0]  temp_ext, on_lim, off_lim;
  logic [THR_W:0]      off_sum;
  logic [THR_W-1:0]    twice;
  logic                log_en;

  always_comb begin
    for (int i = 0; i < NW_EFF; i++) begin
      hit[i] = (item_i.time_hhmm > WIN_LO[i]) && (item_i.time_hhmm < WIN_HI[i]);
    end
  end

  // lowest matching window wins
  always_comb begin
    thr  = cfg_i.default_threshold;
    slot = SLOT_W'(NUM_WINDOWS);
    for (int i = NW_EFF - 1; i >= 0; i--) begin
      if (hit[i]) begin
        thr  = WIN_THR[i];
        slot = SLOT_W'(i);
      end
    end
  end

  assign temp_ext = 14'(item_i.temperature_q4);
  assign on_lim   = $signed({3'b000, thr, 4'b0000});
  assign off_sum  = {1'b0, thr} + {4'b0000, cfg_i.hysteresis_degrees};
  assign off_lim  = $signed({2'b00, off_sum, 4'b0000});

  always_comb begin
    priority if (item_i.opcode == OP_READ) begin
      heater_d = heater_q;
    end else if (!item_i.time_valid) begin
      heater_d = 1'b0;
    end else if (!heater_q && (temp_ext < on_lim)) begin
      heater_d = 1'b1;
    end else if (heater_q && (temp_ext > off_lim)) begin
      heater_d = 1'b0;
    end else begin
      heater_d = heater_q;
    end
  end

  // twice the temperature in degrees, negatives log as zero, clamp at 127
  always_comb begin
    priority if (item_i.temperature_q4[TEMP_W-1]) begin
      twice = '0;
    end else if (item_i.temperature_q4[TEMP_W-2]) begin
      twice = '1;
    end else begin
      twice = item_i.temperature_q4[TEMP_W-3:3];
    end
  end

  assign log_en = (item_i.opcode == OP_TICK) && item_i.time_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q <= 1'b0;
    end else if (step_i) begin
      heater_q <= heater_d;
    end
  end

  assign res_o.heater   = heater_d;
  assign res_o.thr      = thr;
  assign res_o.slot     = slot;
  assign res_o.log_en   = log_en;
  assign res_o.log_byte = log_en ? {heater_d, twice} : '0;

endmodule

`default_nettype wire

@@ hdl/stwh_hist.sv @@
// History ring: synchronous memory, write pointer and wrap flag.
// Entries never written read as zero. Depends on stwh_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stwh_hist import stwh_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 320
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hist_req_t          req_i,
  output logic [ENTRY_W-1:0] rd_data_o,
  output logic [WPOS_W-1:0]  wpos_o
);

  localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned CMP_W = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;

  logic [ENTRY_W-1:0] ring_q [HISTORY_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic               rd_hit_q;
  logic [PTR_W-1:0]   ptr_q, ptr_inc;
  logic               wrapped_q;
  logic [CMP_W-1:0]   idx_ext, ptr_ext;
  logic [PTR_W-1:0]   rd_addr;
  logic               in_range, written;
  logic               ptr_last;

  assign idx_ext  = CMP_W'(req_i.rd_idx);
  assign ptr_ext  = CMP_W'(ptr_q);
  assign rd_addr  = idx_ext[PTR_W-1:0];
  assign in_range = idx_ext < CMP_W'(HISTORY_DEPTH);
  // the ring fills in order from zero, so pointer and wrap flag tell what is written
  assign written  = wrapped_q || (idx_ext < ptr_ext);
  assign ptr_last = ptr_q == PTR_W'(HISTORY_DEPTH - 1);
  assign ptr_inc  = ptr_last ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      ring_q[ptr_q] <= req_i.wr_data;
    end
    if (req_i.rd_en && in_range) begin
      rd_q <= ring_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        ptr_q <= ptr_inc;
        if (ptr_last) begin
          wrapped_q <= 1'b1;
        end
      end
      if (req_i.rd_en) begin
        rd_hit_q <= in_range && written;
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_q : '0;
  assign wpos_o    = WPOS_W'(req_i.wr_en ? ptr_inc : ptr_q);

  `ASSERT_CLK(a_ptr_hold, clk_i, rst_ni, !req_i.wr_en |=> $stable(ptr_q))
  `ASSERT_CLK(a_wrap_sticky, clk_i, rst_ni, wrapped_q |=> wrapped_q)
  `ASSERT_NEVER(a_ptr_range, clk_i, rst_ni, ptr_q > PTR_W'(HISTORY_DEPTH - 1))

endmodule

`default_nettype wire

@@ hdl/scheduled_thermostat_with_history.sv @@
// Scheduled thermostat with history ring, top level.
// Channels: in_i takes ticks (opcode 0) and history reads (opcode 1); out_o
// returns exactly one result item per input item, in order; cfg_i writes
// register 0 (default threshold) and 1 (hysteresis), others are ignored.
// An item is accepted on valid && ready. The control decision and the ring
// write or read happen at the accept edge; the ring read data comes back in the
// cycle after, from the memory's output register.
// An accepted item goes through the ring read stage, then the output register.
// Throughput: one item per cycle while out_o is not stalled; each item uses
// the ring at most once, for a write or a read.
// Two stages (ring read stage, output register) decouple the sides: with the
// output stalled one more item is accepted, then in_i.ready drops until
// out_o is taken.
// Reset: heater off, pointer zero, all history entries read as zero,
// default threshold 40, hysteresis 1. No clearing pass is needed.
// Depends on stwh_pkg, stwh_if, stwh_ctrl, stwh_hist, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scheduled_thermostat_with_history import stwh_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 320,
  parameter int unsigned NUM_WINDOWS   = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stwh_in_if.sink    in_i,
  stwh_out_if.source out_o,
  stwh_cfg_if.sink   cfg_i
);

  cfg_t               cfg_q;
  item_t              item;
  ctrl_res_t          ctrl;
  hist_req_t          hreq;
  logic [ENTRY_W-1:0] rd_data;
  logic [WPOS_W-1:0]  wpos;
  logic               in_acc;
  logic               s1_v_q, o_v_q;
  stage_t             s1_q, s1_d;
  result_t            o_q, o_d;
  logic               s2_free, s1_adv;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_threshold  <= DEFAULT_THR_RST;
      cfg_q.hysteresis_degrees <= HYSTERESIS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DEFAULT_THR: cfg_q.default_threshold  <= cfg_i.data[THR_W-1:0];
        REG_HYSTERESIS:  cfg_q.hysteresis_degrees <= cfg_i.data[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.opcode         = in_i.opcode;
  assign item.time_valid     = in_i.time_valid;
  assign item.time_hhmm      = in_i.time_hhmm;
  assign item.temperature_q4 = in_i.temperature_q4;
  assign item.read_index     = in_i.read_index;

  assign s2_free    = !o_v_q || out_o.ready;
  assign s1_adv     = s1_v_q && s2_free;
  assign in_i.ready = !s1_v_q || s2_free;
  assign in_acc     = in_i.valid && in_i.ready;

  stwh_ctrl #(
    .NUM_WINDOWS(NUM_WINDOWS)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .step_i(in_acc),
    .item_i(item),
    .res_o (ctrl)
  );

  assign hreq.wr_en   = in_acc && ctrl.log_en;
  assign hreq.wr_data = ctrl.log_byte;
  assign hreq.rd_en   = in_acc && (item.opcode == OP_READ);
  assign hreq.rd_idx  = item.read_index;

  stwh_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (hreq),
    .rd_data_o(rd_data),
    .wpos_o   (wpos)
  );

  assign s1_d.heater  = ctrl.heater;
  assign s1_d.thr     = ctrl.thr;
  assign s1_d.slot    = ctrl.slot;
  assign s1_d.is_read = item.opcode == OP_READ;
  assign s1_d.entry   = ctrl.log_byte;
  assign s1_d.wpos    = wpos;

  // read data is held by the memory output register until the next read is accepted
  assign o_d.heater_on      = s1_q.heater;
  assign o_d.threshold      = s1_q.thr;
  assign o_d.schedule_slot  = s1_q.slot;
  assign o_d.history_entry  = s1_q.is_read ? rd_data : s1_q.entry;
  assign o_d.write_position = s1_q.wpos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_v_q <= in_i.valid;
      end
      if (s2_free) begin
        o_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      o_q <= o_d;
    end
  end

  assign out_o.valid          = o_v_q;
  assign out_o.heater_on      = o_q.heater_on;
  assign out_o.threshold      = o_q.threshold;
  assign out_o.schedule_slot  = o_q.schedule_slot;
  assign out_o.history_entry  = o_q.history_entry;
  assign out_o.write_position = o_q.write_position;

  `ASSERT_CLK(a_s1_hold, clk_i, rst_ni, s1_v_q && !s2_free |=> s1_v_q && $stable(s1_q))
  `ASSERT_CLK(a_ready_low_full, clk_i, rst_ni, !in_i.ready |-> s1_v_q && o_v_q)
  `ASSERT_CLK(a_invalid_tick, clk_i, rst_ni,
              in_acc && item.opcode == OP_TICK && !item.time_valid |=> !s1_q.heater && s1_q.entry == '0)

endmodule

`default_nettype wire

@@ test/scheduled_thermostat_with_history_tb.sv @@
// Testbench for scheduled_thermostat_with_history: directed and random ticks and
// history reads with random idling on the input and output sides, results checked in order.
// Depends on stwh_pkg, the stwh_if channel interfaces and the RTL top level.
module scheduled_thermostat_with_history_tb import stwh_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 265;
  localparam int unsigned NUM_PHASES  = 6;
  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // Thermostat behavior: window lookup, hysteresis, history ring, and the
  // queue of results still owed by the block.
  class heater_board;
    localparam int RING_DEPTH = 320;
    localparam int NUM_WIN    = 9;

    logic [HHMM_W-1:0]  win_lo [NUM_WIN];
    logic [HHMM_W-1:0]  win_hi [NUM_WIN];
    logic [THR_W-1:0]   win_thr [NUM_WIN];
    logic [THR_W-1:0]   base_thr;
    logic [HYST_W-1:0]  hyst;
    logic               heater;
    logic [ENTRY_W-1:0] ring [RING_DEPTH];
    int unsigned        wr_ptr;
    result_t            owed_results[$];
    int unsigned        errors, n_ticks, n_invalid, n_reads, n_switches, n_checked;

    function new();
      win_lo  = '{900, 1440, 1500, 1530, 1900, 2100, 2130, 400, 430};
      win_hi  = '{1700, 1501, 1531, 1600, 2101, 2131, 2230, 431, 510};
      win_thr = '{35, 45, 50, 55, 42, 45, 40, 42, 50};
      base_thr = 7'd40;
      hyst = 4'd1;
      heater = 1'b0;
      wr_ptr = 0;
      foreach (ring[i]) ring[i] = '0;
      errors = 0;
      n_ticks = 0;
      n_invalid = 0;
      n_reads = 0;
      n_switches = 0;
      n_checked = 0;
    endfunction

    function void apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEFAULT_THR: base_thr = data[THR_W-1:0];
        REG_HYSTERESIS:  hyst = data[HYST_W-1:0];
        default: ;
      endcase
    endfunction

    // first window that strictly encloses the time wins
    function void pick_window(input logic [HHMM_W-1:0] hhmm, output logic [THR_W-1:0] thr,
                              output logic [SLOT_W-1:0] slot);
      thr = base_thr;
      slot = SLOT_W'(NUM_WIN);
      for (int i = NUM_WIN - 1; i >= 0; i--) begin
        if (hhmm > win_lo[i] && hhmm < win_hi[i]) begin
          thr = win_thr[i];
          slot = SLOT_W'(i);
        end
      end
    endfunction

    function logic [HHMM_W-1:0] boundary_time();
      int unsigned k, b;
      k = $urandom_range(0, NUM_WIN - 1);
      b = $urandom_range(0, 1) ? win_lo[k] : win_hi[k];
      return HHMM_W'(b + $urandom_range(0, 2) - 1);
    endfunction

    function void note_item(input item_t it);
      result_t want;
      int t, twice;
      want.history_entry = '0;
      pick_window(it.time_hhmm, want.threshold, want.schedule_slot);
      if (it.opcode == OP_READ) begin
        n_reads++;
        if (it.read_index < RING_DEPTH) want.history_entry = ring[it.read_index];
      end else if (!it.time_valid) begin
        n_ticks++;
        n_invalid++;
        heater = 1'b0;
      end else begin
        n_ticks++;
        t = $signed(it.temperature_q4);
        if (!heater && t < int'(want.threshold) * 16) begin
          heater = 1'b1;
          n_switches++;
        end else if (heater && t > (int'(want.threshold) + int'(hyst)) * 16) begin
          heater = 1'b0;
          n_switches++;
        end
        twice = (t < 0) ? 0 : t / 8;
        if (twice > 127) twice = 127;
        want.history_entry = {heater, 7'(twice)};
        ring[wr_ptr] = want.history_entry;
        wr_ptr = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
      end
      want.heater_on = heater;
      want.write_position = WPOS_W'(wr_ptr);
      owed_results.push_back(want);
    endfunction

    function void compare_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed: expected none, actual %h", $time, got);
        return;
      end
      want = owed_results.pop_front();
      n_checked++;
      compare_field("heater_on", want.heater_on, got.heater_on);
      compare_field("threshold", want.threshold, got.threshold);
      compare_field("schedule_slot", want.schedule_slot, got.schedule_slot);
      compare_field("history_entry", want.history_entry, got.history_entry);
      compare_field("write_position", want.write_position, got.write_position);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit burst_mode = 1'b0;
  bit hold_request = 1'b0;
  int unsigned longest_hold = 0;
  int unsigned n_settings = 1;
  heater_board board = new();

  stwh_in_if  in_bus ();
  stwh_out_if out_bus ();
  stwh_cfg_if cfg_bus ();

  scheduled_thermostat_with_history dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always #10ns clk_i = ~clk_i;

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t mk_item(input logic op, input logic tv, input int hhmm,
                                    input int temp, input int idx);
    item_t it;
    it.opcode = op;
    it.time_valid = tv;
    it.time_hhmm = HHMM_W'(hhmm);
    it.temperature_q4 = TEMP_W'(temp);
    it.read_index = IDX_W'(idx);
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    logic [THR_W-1:0] thr;
    logic [SLOT_W-1:0] slot;
    int unsigned r;
    int temp;
    it.opcode = ($urandom_range(0, 4) == 0) ? OP_READ : OP_TICK;
    it.time_valid = ($urandom_range(0, 11) != 0);
    r = $urandom_range(0, 19);
    if (r < 9) it.time_hhmm = HHMM_W'($urandom_range(0, 23) * 100 + $urandom_range(0, 59));
    else if (r < 16) it.time_hhmm = board.boundary_time();
    else if (r < 18) it.time_hhmm = HHMM_W'($urandom_range(0, 2359));
    else it.time_hhmm = HHMM_W'($urandom_range(2360, 4095));
    // keep most temperatures around the switching points of the current setting
    board.pick_window(it.time_hhmm, thr, slot);
    r = $urandom_range(0, 19);
    if (r < 12)
      temp = int'(thr) * 16 - 24 + int'($urandom_range(0, (int'(board.hyst) + 3) * 16));
    else if (r < 17) temp = int'($urandom_range(0, 2880)) - 880;
    else temp = int'($urandom);
    it.temperature_q4 = TEMP_W'(temp);
    it.read_index = ($urandom_range(0, 6) != 0) ? IDX_W'($urandom_range(0, 319))
                                                : IDX_W'($urandom_range(320, 511));
    return it;
  endfunction

  task automatic offer_item(input item_t it);
    int unsigned gap;
    in_bus.valid <= 1'b1;
    in_bus.opcode <= it.opcode;
    in_bus.time_valid <= it.time_valid;
    in_bus.time_hhmm <= it.time_hhmm;
    in_bus.temperature_q4 <= it.temperature_q4;
    in_bus.read_index <= it.read_index;
    do @(posedge clk_i); while (!in_bus.ready);
    board.note_item(it);
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk_i);
  endtask

  // both registers, then a write to an unused index that must change nothing
  task automatic program_regs(input logic [CFG_DATA_W-1:0] thr_v,
                              input logic [CFG_DATA_W-1:0] hyst_v);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{REG_DEFAULT_THR, REG_HYSTERESIS, $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO};
    val = '{thr_v, hyst_v, CFG_DATA_W'($urandom)};
    for (int k = 0; k < 3; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data <= val[k];
      do @(posedge clk_i); while (!cfg_bus.ready);
      board.apply_write(idx[k], val[k]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : result_sink
    result_t got;
    int unsigned stall, low_run;
    stall = 0;
    low_run = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        got.heater_on = out_bus.heater_on;
        got.threshold = out_bus.threshold;
        got.schedule_slot = out_bus.schedule_slot;
        got.history_entry = out_bus.history_entry;
        got.write_position = out_bus.write_position;
        board.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !burst_mode && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        stall--;
        low_run++;
        if (low_run > longest_hold) longest_hold = low_run;
        out_bus.ready <= 1'b0;
      end else begin
        low_run = 0;
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("scheduled_thermostat_with_history_tb: errors");
    $finish;
  end

  initial begin : stimulus
    item_t directed[$];
    logic [CFG_DATA_W-1:0] thr_set [NUM_PHASES];
    logic [CFG_DATA_W-1:0] hyst_set [NUM_PHASES];
    rst_ni <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.opcode <= OP_TICK;
    in_bus.time_valid <= 1'b0;
    in_bus.time_hhmm <= '0;
    in_bus.temperature_q4 <= '0;
    in_bus.read_index <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_DEFAULT_THR;
    cfg_bus.data <= '0;
    // upper data bits set in some settings to check the register widths
    thr_set = '{8'd40, 8'd0, 8'd127, 8'hFF, 8'd0, 8'd20};
    hyst_set = '{8'd1, 8'd0, 8'd15, 8'hF3, 8'd0, 8'd6};
    thr_set[4] = CFG_DATA_W'($urandom);
    hyst_set[4] = CFG_DATA_W'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: window edges, field extremes, invalid clock, odd read indexes
    directed = '{
      mk_item(OP_READ, 1'b1, 1200, 0, 0),
      mk_item(OP_READ, 1'b0, 4095, -2048, 511),
      mk_item(OP_TICK, 1'b1, 1200, 2047, 0),
      mk_item(OP_TICK, 1'b1, 2000, -2048, 0),
      mk_item(OP_TICK, 1'b1, 2101, 720, 0),
      mk_item(OP_TICK, 1'b1, 2131, 657, 0),
      mk_item(OP_TICK, 1'b1, 401, 671, 0),
      mk_item(OP_TICK, 1'b1, 509, 817, 0),
      mk_item(OP_TICK, 1'b1, 430, -1, 0),
      mk_item(OP_TICK, 1'b0, 1000, 0, 0),
      mk_item(OP_TICK, 1'b1, 900, 639, 0),
      mk_item(OP_TICK, 1'b1, 1700, 2000, 0),
      mk_item(OP_TICK, 1'b1, 2359, 8, 0),
      mk_item(OP_TICK, 1'b1, 0, 7, 0),
      mk_item(OP_TICK, 1'b1, 4095, 1015, 0),
      mk_item(OP_TICK, 1'b1, 1501, -880, 0),
      mk_item(OP_TICK, 1'b1, 2230, 2000, 0),
      mk_item(OP_READ, 1'b0, 2130, 1234, 2),
      mk_item(OP_READ, 1'b1, 1441, -5, 319),
      mk_item(OP_READ, 1'b1, 0, 0, 320),
      mk_item(OP_TICK, 1'b0, 4095, 2047, 511),
      mk_item(OP_READ, 1'b1, 2359, 0, 11)
    };
    foreach (directed[i]) offer_item(directed[i]);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        program_regs(thr_set[p], hyst_set[p]);
        n_settings++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) burst_mode = ($urandom_range(0, 4) == 0);
        // long output stall while items keep coming, so the input backs up
        if (p == 1 && n == 100) begin
          hold_request = 1'b1;
          burst_mode = 1'b1;
        end
        if (p == 3 && n == 130) wait_idle();
        offer_item(random_item());
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    $display("run: %0d ticks (%0d with clock unset), %0d history reads, %0d heater switches",
             board.n_ticks, board.n_invalid, board.n_reads, board.n_switches);
    $display("run: %0d results checked over %0d register settings, longest output stall %0d",
             board.n_checked, n_settings, longest_hold);
    if (board.errors == 0 && board.owed_results.size() == 0) begin
      $display("scheduled_thermostat_with_history_tb: clean");
    end else begin
      $display("scheduled_thermostat_with_history_tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/stwh_pkg.sv
hdl/stwh_if.sv
hdl/stwh_ctrl.sv
hdl/stwh_hist.sv
hdl/scheduled_thermostat_with_history.sv
test/scheduled_thermostat_with_history_tb.sv
